// ----- hw/rtl/slirm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slirm_pkg;

    localparam int CAPACITY = 15;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_LAST,
        S_REM_READ,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/slirm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface slirm_req_if;
    logic                               valid;
    logic                               ready;
    logic [slirm_pkg::KIND_W-1:0]       kind;
    logic signed [slirm_pkg::VAL_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface slirm_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [slirm_pkg::STAT_W-1:0]       status;
    logic [slirm_pkg::CNT_W-1:0]        entry_count;
    logic signed [slirm_pkg::VAL_W-1:0] removed_value;

    modport source (output valid, output status, output entry_count, output removed_value,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input removed_value,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/slirm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slirm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_list_insert_remove_max.sv -----
// After a transfer, the result is registered from S_FINISH once the output slot is free.
// Clear, refused insert, insert into an empty store, remove on empty and unused kinds go
// straight to S_FINISH; remove first takes the top entry in S_REM_READ (one RAM read).
// Insert into a held list walks from the top, one RAM read and one write per cycle.
// req.ready returns when the result is registered; that result may wait for rsp.ready.
// Reset (rst_n low, asynchronous) empties the count; store unswept.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_remove_max (
    input wire logic   clk,
    input wire logic   rst_n,
    slirm_req_if.sink  req,
    slirm_rsp_if.source rsp
);

    slirm_pkg::state_t state_reg, state_next;

    logic [slirm_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [slirm_pkg::ADDR_W-1:0]       idx_reg, idx_next;
    logic signed [slirm_pkg::VAL_W-1:0] val_reg, val_next;
    logic [slirm_pkg::STAT_W-1:0]       res_status_reg, res_status_next;
    logic signed [slirm_pkg::VAL_W-1:0] res_value_reg, res_value_next;

    logic                               out_valid_reg, out_valid_next;
    logic [slirm_pkg::STAT_W-1:0]       out_status_reg, out_status_next;
    logic [slirm_pkg::CNT_W-1:0]        out_count_reg, out_count_next;
    logic signed [slirm_pkg::VAL_W-1:0] out_value_reg, out_value_next;

    logic                               ram_we;
    logic [slirm_pkg::ADDR_W-1:0]       ram_waddr;
    logic [slirm_pkg::VAL_W-1:0]        ram_wdata;
    logic [slirm_pkg::ADDR_W-1:0]       ram_raddr;
    logic [slirm_pkg::VAL_W-1:0]        ram_rdata;

    logic req_xfer;
    logic slot_free;
    logic shift_up;
    logic is_full;
    logic is_empty;
    logic [slirm_pkg::ADDR_W-1:0] top_addr;

    slirm_ram #(
        .WIDTH (slirm_pkg::VAL_W),
        .DEPTH (slirm_pkg::CAPACITY),
        .ADDR_W(slirm_pkg::ADDR_W)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req.ready = (state_reg == slirm_pkg::S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign shift_up  = ($signed(ram_rdata) >= val_reg);
    assign is_full   = (count_reg == slirm_pkg::CNT_W'(slirm_pkg::CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign top_addr  = slirm_pkg::ADDR_W'(count_reg - 1'b1);

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_count   = out_count_reg;
    assign rsp.removed_value = out_value_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            slirm_pkg::S_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req.kind == slirm_pkg::KIND_INSERT && !is_full && !is_empty)
                    begin
                        state_next = slirm_pkg::S_INS_SCAN;
                    end
                    else if (req.kind == slirm_pkg::KIND_REMOVE && !is_empty)
                    begin
                        state_next = slirm_pkg::S_REM_READ;
                    end
                    else
                    begin
                        state_next = slirm_pkg::S_FINISH;
                    end
                end
            end
            slirm_pkg::S_INS_SCAN:
            begin
                if (!shift_up)
                begin
                    state_next = slirm_pkg::S_FINISH;
                end
                else if (idx_reg == '0)
                begin
                    state_next = slirm_pkg::S_INS_LAST;
                end
            end
            slirm_pkg::S_INS_LAST:
            begin
                state_next = slirm_pkg::S_FINISH;
            end
            slirm_pkg::S_REM_READ:
            begin
                state_next = slirm_pkg::S_FINISH;
            end
            slirm_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = slirm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slirm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_value_next  = out_value_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = val_reg;
        ram_raddr       = idx_reg;
        unique case (state_reg)
            slirm_pkg::S_IDLE:
            begin
                ram_raddr = top_addr;
                if (req_xfer)
                begin
                    val_next        = req.value;
                    idx_next        = top_addr;
                    res_status_next = slirm_pkg::ST_DONE;
                    res_value_next  = '0;
                    case (req.kind)
                        slirm_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        slirm_pkg::KIND_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_status_next = slirm_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                if (is_empty)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = '0;
                                    ram_wdata = req.value;
                                end
                            end
                        end
                        slirm_pkg::KIND_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = slirm_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            slirm_pkg::S_INS_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = slirm_pkg::ADDR_W'(idx_reg + 1'b1);
                ram_wdata = shift_up ? ram_rdata : val_reg;
                ram_raddr = slirm_pkg::ADDR_W'(idx_reg - 1'b1);
                if (shift_up && idx_reg != '0)
                begin
                    idx_next = slirm_pkg::ADDR_W'(idx_reg - 1'b1);
                end
            end
            slirm_pkg::S_INS_LAST:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = val_reg;
            end
            slirm_pkg::S_REM_READ:
            begin
                res_value_next = $signed(ram_rdata);
            end
            slirm_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    out_value_next  = res_value_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slirm_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_value_reg  <= out_value_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/slirm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slirm_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               rsp_valid,
    input wire logic                               rsp_ready,
    input wire logic [slirm_pkg::STAT_W-1:0]       rsp_status,
    input wire logic [slirm_pkg::CNT_W-1:0]        rsp_entry_count,
    input wire logic signed [slirm_pkg::VAL_W-1:0] rsp_removed_value
);

    localparam logic [slirm_pkg::CNT_W-1:0] CAP = slirm_pkg::CNT_W'(slirm_pkg::CAPACITY);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_entry_count <= CAP)
        else $error("entry count beyond capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == slirm_pkg::ST_FULL |-> rsp_entry_count == CAP)
        else $error("full status with spare room");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == slirm_pkg::ST_EMPTY |-> rsp_entry_count == '0)
        else $error("empty status with entries held");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != slirm_pkg::ST_DONE |-> rsp_removed_value == '0)
        else $error("removed value on a failed operation");

endmodule

bind sorted_list_insert_remove_max slirm_checker u_slirm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_entry_count  (rsp.entry_count),
    .rsp_removed_value(rsp.removed_value)
);

`default_nettype wire
